// ===== design/mdp_pkg.sv =====
package mdp_pkg;

    localparam int MONTH_W   = 4;
    localparam int YEAR_W    = 14;
    localparam int PROFILE_W = 8;
    localparam int MASK_W    = 8;
    localparam int DAY_W     = 5;
    localparam int WDAY_W    = 3;

    localparam logic [MONTH_W-1:0]   MAX_MONTH  = 4'd12;
    localparam logic [YEAR_W-1:0]    MAX_YEAR   = 14'd9999;
    localparam logic [PROFILE_W-1:0] NO_PROFILE = 8'hFF;
    localparam logic [2:0]           FIRST_OFFSET = 3'd5;

    // Division by 100 and by 7 as reciprocal multiplication, exact over the valid years.
    localparam int MUL_B_W  = 15;
    localparam int PROD_W   = YEAR_W + MUL_B_W;
    localparam logic [MUL_B_W-1:0] RECIP_100 = 15'd5243;
    localparam int SHIFT_100 = 19;
    localparam logic [MUL_B_W-1:0] RECIP_7 = 15'd18725;
    localparam int SHIFT_7 = 17;
    localparam int Q100_W = 7;
    localparam int Q7_W = 12;

    localparam logic [1:0] MUL_YEAR  = 2'd0;
    localparam logic [1:0] MUL_SHIFT = 2'd1;
    localparam logic [1:0] MUL_SUM   = 2'd2;

    typedef struct packed {
        logic [MONTH_W-1:0]   month_number;
        logic [YEAR_W-1:0]    year_number;
        logic [PROFILE_W-1:0] profile_number;
        logic [MASK_W-1:0]    weekday_mask;
    } req_t;

    typedef struct packed {
        logic [DAY_W-1:0]     day_index;
        logic [PROFILE_W-1:0] day_profile;
        logic [WDAY_W-1:0]    weekday_of_day;
        logic                 last_day;
        logic                 bad_request;
    } day_t;

    typedef struct packed {
        logic       in_ready;
        logic       load_req;
        logic       mul_en;
        logic [1:0] mul_op;
        logic       cap_qy;
        logic       cap_sum;
        logic       cap_wday;
        logic       emit_day;
        logic       emit_err;
    } ctrl_cmd_t;

    typedef struct packed {
        logic bad_in;
        logic last;
        logic slot_free;
    } dp_status_t;

    // Integer part of 23 * m / 9 for months 1 to 12.
    function automatic logic [4:0] month_term(input logic [MONTH_W-1:0] m);
        logic [4:0] t;
        begin
            case (m)
                4'd1:    t = 5'd2;
                4'd2:    t = 5'd5;
                4'd3:    t = 5'd7;
                4'd4:    t = 5'd10;
                4'd5:    t = 5'd12;
                4'd6:    t = 5'd15;
                4'd7:    t = 5'd17;
                4'd8:    t = 5'd20;
                4'd9:    t = 5'd23;
                4'd10:   t = 5'd25;
                4'd11:   t = 5'd28;
                4'd12:   t = 5'd30;
                default: t = 5'd0;
            endcase
            return t;
        end
    endfunction

endpackage

// ===== design/mdp_req_if.sv =====
interface mdp_req_if;
    logic           valid;
    logic           ready;
    mdp_pkg::req_t  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== design/mdp_day_if.sv =====
interface mdp_day_if;
    logic           valid;
    logic           ready;
    mdp_pkg::day_t  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== design/mdp_controller.sv =====
module mdp_controller (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    input  mdp_pkg::dp_status_t    status,
    output mdp_pkg::ctrl_cmd_t     cmd
);
    import mdp_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MULY  = 3'd1;
    localparam logic [2:0] S_MULZ  = 3'd2;
    localparam logic [2:0] S_SUM   = 3'd3;
    localparam logic [2:0] S_MOD   = 3'd4;
    localparam logic [2:0] S_REM   = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;
    localparam logic [2:0] S_ERR   = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = status.bad_in ? S_ERR : S_MULY;
                end
            end
            S_MULY:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = MUL_YEAR;
                state_next = S_MULZ;
            end
            S_MULZ:
            begin
                cmd.cap_qy = 1'b1;
                cmd.mul_en = 1'b1;
                cmd.mul_op = MUL_SHIFT;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.cap_sum = 1'b1;
                state_next  = S_MOD;
            end
            S_MOD:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = MUL_SUM;
                state_next = S_REM;
            end
            S_REM:
            begin
                cmd.cap_wday = 1'b1;
                state_next   = S_EMIT;
            end
            S_EMIT:
            begin
                if (status.slot_free)
                begin
                    cmd.emit_day = 1'b1;
                    if (status.last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_ERR:
            begin
                if (status.slot_free)
                begin
                    cmd.emit_err = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/mdp_datapath.sv =====
module mdp_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  mdp_pkg::req_t          req_data,
    input  mdp_pkg::ctrl_cmd_t     cmd,
    input  logic                   day_ready,
    output logic                   day_valid,
    output mdp_pkg::day_t          day_data,
    output mdp_pkg::dp_status_t    status
);
    import mdp_pkg::*;

    logic [MONTH_W-1:0]   month_reg;
    logic [YEAR_W-1:0]    year_reg;
    logic [PROFILE_W-1:0] profile_reg;
    logic [MASK_W-1:0]    mask_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [Q100_W-1:0]    qy_reg;
    logic [YEAR_W-1:0]    sum_reg;
    logic [DAY_W-1:0]     mlen_reg;
    logic [DAY_W-1:0]     day_reg;
    logic [WDAY_W-1:0]    wday_reg;
    logic                 out_valid_reg;
    day_t                 out_reg;

    logic                 early_month;
    logic [YEAR_W-1:0]    shifted_year;
    logic [YEAR_W-1:0]    mul_a;
    logic [MUL_B_W-1:0]   mul_b;
    logic [Q100_W-1:0]    qz;
    logic [14:0]          sum_next;
    logic [YEAR_W-1:0]    rem100;
    logic                 leap;
    logic [MONTH_W-1:0]   month_fold;
    logic [DAY_W-1:0]     mlen_next;
    logic [Q7_W-1:0]      q7;
    logic [YEAR_W-1:0]    rem7;
    logic [WDAY_W-1:0]    wday_first;
    logic                 last;

    assign early_month  = (month_reg < 4'd3);
    assign shifted_year = early_month ? (year_reg - 14'd1) : year_reg;

    always_comb
    begin
        case (cmd.mul_op)
            MUL_YEAR:
            begin
                mul_a = year_reg;
                mul_b = RECIP_100;
            end
            MUL_SHIFT:
            begin
                mul_a = shifted_year;
                mul_b = RECIP_100;
            end
            default:
            begin
                mul_a = sum_reg;
                mul_b = RECIP_7;
            end
        endcase
    end

    assign qz = prod_reg[SHIFT_100 +: Q100_W];

    assign sum_next = 15'(month_term(month_reg)) + 15'(FIRST_OFFSET) + 15'(year_reg)
                    + 15'(shifted_year >> 2) - 15'(qz) + 15'(qz >> 2)
                    - (early_month ? 15'd0 : 15'd2);

    assign rem100 = year_reg - (14'(qy_reg) * 14'd100);
    assign leap   = (year_reg[1:0] == 2'b00) && ((rem100 != '0) || (qy_reg[1:0] == 2'b00));

    always_comb
    begin
        month_fold = (month_reg > 4'd7) ? (month_reg - 4'd1) : month_reg;
        if (month_reg == 4'd2)
        begin
            mlen_next = leap ? 5'd29 : 5'd28;
        end
        else
        begin
            mlen_next = month_fold[0] ? 5'd31 : 5'd30;
        end
    end

    assign q7         = prod_reg[SHIFT_7 +: Q7_W];
    assign rem7       = sum_reg - (14'(q7) * 14'd7);
    assign wday_first = (rem7[WDAY_W-1:0] == 3'd0) ? 3'd7 : rem7[WDAY_W-1:0];

    assign last = (day_reg == mlen_reg);

    assign status.bad_in = (req_data.month_number == 4'd0)
                        || (req_data.month_number > MAX_MONTH)
                        || (req_data.year_number == 14'd0)
                        || (req_data.year_number > MAX_YEAR);
    assign status.last      = last;
    assign status.slot_free = !out_valid_reg || day_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            month_reg   <= req_data.month_number;
            year_reg    <= req_data.year_number;
            profile_reg <= req_data.profile_number;
            mask_reg    <= req_data.weekday_mask;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
        end
        if (cmd.cap_qy)
        begin
            qy_reg <= prod_reg[SHIFT_100 +: Q100_W];
        end
        if (cmd.cap_sum)
        begin
            sum_reg  <= sum_next[YEAR_W-1:0];
            mlen_reg <= mlen_next;
        end
        if (cmd.cap_wday)
        begin
            wday_reg <= wday_first;
            day_reg  <= 5'd1;
        end
        else if (cmd.emit_day)
        begin
            day_reg  <= day_reg + 5'd1;
            wday_reg <= (wday_reg == 3'd7) ? 3'd1 : (wday_reg + 3'd1);
        end
        if (cmd.emit_day)
        begin
            out_reg.day_index      <= day_reg;
            out_reg.day_profile    <= mask_reg[wday_reg] ? profile_reg : NO_PROFILE;
            out_reg.weekday_of_day <= wday_reg;
            out_reg.last_day       <= last;
            out_reg.bad_request    <= 1'b0;
        end
        else if (cmd.emit_err)
        begin
            out_reg.day_index      <= '0;
            out_reg.day_profile    <= NO_PROFILE;
            out_reg.weekday_of_day <= '0;
            out_reg.last_day       <= 1'b1;
            out_reg.bad_request    <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_day || cmd.emit_err)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (day_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign day_valid = out_valid_reg;
    assign day_data  = out_reg;

endmodule

// ===== design/month_day_profile_generator.sv =====
// Channel  Role    Payload
// req      sink    month_number, year_number, profile_number, weekday_mask
// day      source  day_index, day_profile, weekday_of_day, last_day, bad_request
//
// A request runs set-up states (three passes through one shared reciprocal
// multiplier), then gives one day result per cycle while the day channel accepts,
// or one error result if flagged; a new request is taken only when done.
// Reset clears the sequencer and the output valid flag; no clearing pass is needed.
// A stalled day channel holds the current result in the output register and
// pauses the day sequencer until the transfer completes.
module month_day_profile_generator (
    input  logic       clk,
    input  logic       rst_n,
    mdp_req_if.sink    req,
    mdp_day_if.source  day
);
    import mdp_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign req.ready = cmd.in_ready;

    mdp_controller u_controller (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .status    (status),
        .cmd       (cmd)
    );

    mdp_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req.data),
        .cmd       (cmd),
        .day_ready (day.ready),
        .day_valid (day.valid),
        .day_data  (day.data),
        .status    (status)
    );

endmodule

// ===== dv/mdp_calendar_check.sv =====
`timescale 1ns / 100ps

module mdp_calendar_check (
    input  logic clk,
    input  logic rst_n,
    mdp_req_if   req,
    mdp_day_if   day,
    output int   failures,
    output int   days_pending
);
    import mdp_pkg::*;

    day_t expected_days[$];

    initial
    begin
        failures     = 0;
        days_pending = 0;
    end

    // Expands one request into the day results that the block should emit for it.
    task automatic queue_month_days(input req_t r);
        int   m;
        int   y;
        int   z;
        int   s;
        int   len;
        int   wd;
        day_t d;
        m = r.month_number;
        y = r.year_number;
        d = '0;
        if (m < 1 || m > MAX_MONTH || y < 1 || y > MAX_YEAR)
        begin
            d.day_profile = NO_PROFILE;
            d.last_day    = 1'b1;
            d.bad_request = 1'b1;
            expected_days.push_back(d);
            return;
        end
        if (m == 2)
            len = ((y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0))) ? 29 : 28;
        else
            len = ((((m > 7) ? m - 1 : m) % 2) == 0) ? 30 : 31;
        z  = (m < 3) ? y - 1 : y;
        s  = (23 * m) / 9 + 5 + y + z / 4 - z / 100 + z / 400 - ((m < 3) ? 0 : 2);
        wd = s % 7;
        if (wd == 0)
            wd = 7;
        for (int k = 1; k <= len; k++)
        begin
            d.day_index      = DAY_W'(k);
            d.weekday_of_day = WDAY_W'(wd);
            d.day_profile    = r.weekday_mask[wd] ? r.profile_number : NO_PROFILE;
            d.last_day       = (k == len);
            d.bad_request    = 1'b0;
            expected_days.push_back(d);
            wd = (wd == 7) ? 1 : wd + 1;
        end
    endtask

    function automatic int field_mismatch(input string name, input int exp_val,
                                          input int act_val);
        if (exp_val != act_val)
        begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk)
    begin
        day_t exp_day;
        day_t got_day;
        int   errs;
        if (rst_n)
        begin
            if (req.valid === 1'b1 && req.ready === 1'b1)
                queue_month_days(req.data);
            if (day.valid === 1'b1 && day.ready === 1'b1)
            begin
                got_day = day.data;
                if (expected_days.size() == 0)
                begin
                    $error("day result with none expected: day_index %0d",
                           got_day.day_index);
                    failures = failures + 1;
                end
                else
                begin
                    exp_day = expected_days.pop_front();
                    errs = field_mismatch("day_index", exp_day.day_index,
                                          got_day.day_index)
                         + field_mismatch("day_profile", exp_day.day_profile,
                                          got_day.day_profile)
                         + field_mismatch("weekday_of_day", exp_day.weekday_of_day,
                                          got_day.weekday_of_day)
                         + field_mismatch("last_day", exp_day.last_day,
                                          got_day.last_day)
                         + field_mismatch("bad_request", exp_day.bad_request,
                                          got_day.bad_request);
                    if (errs != 0)
                        failures = failures + 1;
                end
            end
        end
        days_pending <= expected_days.size();
    end

endmodule

// ===== dv/month_day_profile_generator_tb.sv =====
`timescale 1ns / 100ps

module month_day_profile_generator_tb;
    import mdp_pkg::*;

    localparam int RANDOM_REQUESTS = 300;
    localparam int IDLE_LIMIT      = 2000;
    localparam int DRAIN_CYCLES    = 60;

    logic clk;
    logic rst_n;
    int   check_failures;
    int   days_pending;
    int   idle_cycles;
    int   burst_left;

    mdp_req_if req_ch ();
    mdp_day_if day_ch ();

    month_day_profile_generator i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .day   (day_ch)
    );

    mdp_calendar_check i_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req_ch),
        .day          (day_ch),
        .failures     (check_failures),
        .days_pending (days_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #10 clk = ~clk;
    end

    function automatic req_t make_req(input int m, input int y, input int p, input int mask);
        req_t r;
        r.month_number   = MONTH_W'(m);
        r.year_number    = YEAR_W'(y);
        r.profile_number = PROFILE_W'(p);
        r.weekday_mask   = MASK_W'(mask);
        return r;
    endfunction

    function automatic req_t random_request();
        int sel;
        int m;
        int y;
        int mask;
        sel  = $urandom_range(0, 99);
        m    = $urandom_range(1, 12);
        y    = $urandom_range(1, 9999);
        mask = $urandom_range(0, 255);
        if (sel < 20)
        begin
            case ($urandom_range(0, 7))
                0: y = 1;
                1: y = 4;
                2: y = 100;
                3: y = 400;
                4: y = 1900;
                5: y = 2000;
                6: y = 9996;
                default: y = 9999;
            endcase
            if ($urandom_range(0, 1) == 1)
                m = 2;
        end
        else if (sel < 26)
            m = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(13, 15);
        else if (sel < 32)
            y = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10000, 16383);
        if ($urandom_range(0, 9) == 0)
            mask = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
        return make_req(m, y, $urandom_range(0, 255), mask);
    endfunction

    task automatic drive_request(input req_t r);
        if (burst_left == 0)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(0, 12))
                @(negedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? 30 : $urandom_range(1, 6);
        end
        burst_left = burst_left - 1;
        @(negedge clk);
        req_ch.valid <= 1'b1;
        req_ch.data  <= r;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
    endtask

    // The day channel stalls in segments: always ready, mostly ready, or mostly stalled.
    initial
    begin
        int seg_len;
        int mode;
        day_ch.ready = 1'b0;
        forever
        begin
            seg_len = $urandom_range(10, 200);
            mode    = $urandom_range(0, 2);
            repeat (seg_len)
            begin
                @(negedge clk);
                case (mode)
                    0: day_ch.ready <= 1'b1;
                    1: day_ch.ready <= ($urandom_range(0, 3) != 0);
                    default: day_ch.ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
            || (day_ch.valid === 1'b1 && day_ch.ready === 1'b1))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("month_day_profile_generator_tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        idle_cycles  = 0;
        burst_left   = 0;
        repeat (4)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        drive_request(make_req(1, 1, 0, 8'hFF));
        drive_request(make_req(12, 9999, 255, 8'hFE));
        drive_request(make_req(2, 2000, 7, 8'h80));
        drive_request(make_req(2, 1900, 8, 8'h02));
        drive_request(make_req(2, 2024, 9, 8'h55));
        drive_request(make_req(2, 2023, 10, 8'hAA));
        for (int m = 3; m <= 12; m++)
            drive_request(make_req(m, 2025, 16 * m, 8'h3C));
        drive_request(make_req(7, 2021, 3, 8'h01));
        drive_request(make_req(6, 2022, 0, 8'h00));
        drive_request(make_req(0, 2000, 1, 8'hFF));
        drive_request(make_req(13, 2000, 2, 8'hFF));
        drive_request(make_req(15, 2000, 3, 8'hFF));
        drive_request(make_req(5, 0, 4, 8'hFF));
        drive_request(make_req(5, 10000, 5, 8'hFF));
        drive_request(make_req(5, 16383, 6, 8'hFF));
        drive_request(make_req(0, 0, 255, 8'h00));

        repeat (RANDOM_REQUESTS)
            drive_request(random_request());

        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (days_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (check_failures == 0)
            $display("month_day_profile_generator_tb: PASS");
        else
            $display("month_day_profile_generator_tb: FAIL");
        $finish;
    end

endmodule
